// ===== rtl/pd_controller_angle_wrap_assert.svh =====
// ----------------------------------------------------------------------------
// pd_controller_angle_wrap assertion macros
// shorthand for clocked checks, with reset held off
// ----------------------------------------------------------------------------
`ifndef PD_CONTROLLER_ANGLE_WRAP_ASSERT_SVH
`define PD_CONTROLLER_ANGLE_WRAP_ASSERT_SVH

// same-cycle implication
`define PDC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define PDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// shared constants and types of the pd controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // divider widths
  localparam int DVD_W = 48;
  localparam int DVS_W = 32;

  localparam logic [16:0] ALPHA_MIN = 17'd655;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // register indexes
  localparam logic [2:0] REG_GAIN_P   = 3'd0;
  localparam logic [2:0] REG_GAIN_D   = 3'd1;
  localparam logic [2:0] REG_ALPHA    = 3'd2;
  localparam logic [2:0] REG_DEADBAND = 3'd3;
  localparam logic [2:0] REG_EN_P     = 3'd4;
  localparam logic [2:0] REG_EN_D     = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/pd_controller_angle_wrap.sv =====
// ----------------------------------------------------------------------------
// pd_controller_angle_wrap
// fixed-point pd controller with angle wrapping and filtered derivative
// ----------------------------------------------------------------------------
// A sample passes the wrap and deadband logic and the first products, then
// the 48-step bit-serial divider that turns the measurement change into a
// rate, then the remaining passes through the one shared 33x33 multiplier
// (six passes in all) and the output stage. A reload command goes straight
// to the output stage. in_ready is high only while no item is in flight, so
// the block takes no new item before it is done with the last; the result
// sits in an output register, so a new item is taken while it waits.
// Configuration writes are taken in any cycle and belong between items.
`timescale 1ns / 1ps

module pd_controller_angle_wrap #(
  parameter int FRAC_BITS = pdc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic signed [25:0] in_measured,
  input  logic signed [25:0] in_setpoint,
  input  logic               in_angle_mode,
  input  logic [31:0]        in_elapsed_us,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_drive,
  output logic               out_saturated
);

  localparam int MW = pdc_pkg::MUL_W;
  localparam int PW = pdc_pkg::PROD_W;
  localparam int WW = 36;   // wrap arithmetic width
  localparam int EW = 28;   // error and change width
  localparam int TW = 62;   // p term and sum width

  localparam logic signed [WW-1:0] HALF = 36'sd180 <<< FRAC_BITS;
  localparam logic signed [WW-1:0] FULL = 36'sd360 <<< FRAC_BITS;
  localparam logic signed [TW-1:0] LIM  = 62'sd100 <<< FRAC_BITS;
  localparam logic signed [23:0]   LIM24 = LIM[23:0];
  localparam logic signed [MW-1:0] SPEED_SCALE = 33'sd1000000;
  localparam logic signed [MW-1:0] RECIP10 = 33'sh0CCCCCCCD;   // 2^35 / 10, rounded up
  localparam logic signed [31:0]   S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0]   S32_MIN = 32'sh80000000;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CALC = 4'd1;
  localparam logic [3:0] ST_MP   = 4'd2;
  localparam logic [3:0] ST_MC   = 4'd3;
  localparam logic [3:0] ST_DS   = 4'd4;
  localparam logic [3:0] ST_DW   = 4'd5;
  localparam logic [3:0] ST_MD   = 4'd6;
  localparam logic [3:0] ST_RW   = 4'd7;
  localparam logic [3:0] ST_MA   = 4'd8;
  localparam logic [3:0] ST_MB   = 4'd9;
  localparam logic [3:0] ST_MF   = 4'd10;
  localparam logic [3:0] ST_MT   = 4'd11;
  localparam logic [3:0] ST_TQ   = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  function automatic logic signed [WW-1:0] wrap_angle(input logic signed [WW-1:0] d);
    logic signed [WW-1:0] x;
    x = d;
    if (x > HALF) x = x - FULL;
    if (x > HALF) x = x - FULL;
    if (x < -HALF) x = x + FULL;
    if (x < -HALF) x = x + FULL;
    return x;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (v > PW'(S32_MAX)) return S32_MAX;
    if (v < PW'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  // configuration registers
  logic signed [31:0] gain_p_r;
  logic signed [31:0] gain_d_r;
  logic [16:0]        alpha_r;
  logic [30:0]        dband_r;
  logic               en_p_r;
  logic               en_d_r;

  // loop state
  logic signed [25:0] prev_r;
  logic signed [31:0] filt_r;

  // working registers
  logic [3:0]           state_r;
  logic signed [25:0]   meas_r;
  logic signed [25:0]   sp_r;
  logic                 angle_r;
  logic [31:0]          us_r;
  logic signed [EW-1:0] err_r;
  logic signed [EW-1:0] chg_r;
  logic signed [TW-1:0] pterm_r;
  logic                 neg_r;
  logic signed [31:0]   speed_r;
  logic signed [31:0]   raw_r;
  logic signed [PW-1:0] acc_r;
  logic signed [29:0]   q_r;
  logic                 out_valid_r;
  logic signed [23:0]   drive_r;
  logic                 sat_r;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic                 div_start;
  logic [pdc_pkg::DVD_W-1:0] div_dvd;
  logic [pdc_pkg::DVD_W-1:0] div_q;
  pdc_pkg::div_stat_t   div_stat;

  logic signed [WW-1:0] err_w;
  logic signed [WW-1:0] err_abs;
  logic signed [WW-1:0] chg_w;
  logic signed [PW-1:0] prod_mag;
  logic signed [MW-1:0] filt_abs;
  logic [16:0]          alpha_in;
  logic signed [TW-1:0] total;
  logic                 out_free;

  // error with wrap and deadband, measurement change with wrap
  always_comb begin
    err_w = WW'(sp_r) - WW'(meas_r);
    if (angle_r) err_w = wrap_angle(err_w);
    err_abs = (err_w < 0) ? -err_w : err_w;
    if ($unsigned(err_abs) < {5'b0, dband_r}) err_w = '0;
    chg_w = WW'(meas_r) - WW'(prev_r);
    if (angle_r) chg_w = wrap_angle(chg_w);
  end

  // operand select for the shared multiplier, product read one state later
  always_comb begin
    filt_abs = (filt_r < 0) ? -MW'(filt_r) : MW'(filt_r);
    case (state_r)
      ST_MP: begin
        mul_a = MW'(err_r);
        mul_b = MW'(gain_p_r);
      end
      ST_MC: begin
        mul_a = MW'(chg_r);
        mul_b = SPEED_SCALE;
      end
      ST_MD: begin
        mul_a = MW'(speed_r);
        mul_b = MW'(gain_d_r);
      end
      ST_MA: begin
        mul_a = $signed({16'b0, alpha_r});
        mul_b = MW'(raw_r);
      end
      ST_MB: begin
        mul_a = $signed({16'b0, pdc_pkg::ALPHA_ONE - alpha_r});
        mul_b = MW'(filt_r);
      end
      ST_MT: begin
        mul_a = filt_abs;
        mul_b = RECIP10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_mag  = (mul_p < 0) ? -mul_p : mul_p;
  assign div_dvd   = prod_mag[pdc_pkg::DVD_W-1:0];
  assign div_start = (state_r == ST_DS);

  assign total = (en_p_r ? pterm_r : '0) - (en_d_r ? TW'(q_r) : '0);
  assign out_free = !out_valid_r || out_ready;

  pdc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  pdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (us_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // configuration writes, alpha clamped into range
  always_comb begin
    alpha_in = cfg_data[16:0];
    if (alpha_in < pdc_pkg::ALPHA_MIN) alpha_in = pdc_pkg::ALPHA_MIN;
    if (alpha_in > pdc_pkg::ALPHA_ONE) alpha_in = pdc_pkg::ALPHA_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 32'sd1 <<< FRAC_BITS;
      gain_d_r <= '0;
      alpha_r  <= pdc_pkg::ALPHA_ONE;
      dband_r  <= '0;
      en_p_r   <= 1'b1;
      en_d_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pdc_pkg::REG_GAIN_P:   gain_p_r <= cfg_data;
        pdc_pkg::REG_GAIN_D:   gain_d_r <= cfg_data;
        pdc_pkg::REG_ALPHA:    alpha_r  <= alpha_in;
        pdc_pkg::REG_DEADBAND: dband_r  <= cfg_data[30:0];
        pdc_pkg::REG_EN_P:     en_p_r   <= cfg_data[0];
        pdc_pkg::REG_EN_D:     en_d_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register loads from the last state, holds until its transfer
      out_valid_r <= (state_r == ST_FIN && out_free) || (out_valid_r && !out_ready);
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_func) begin
              // reload: new previous value, filter cleared, zero result
              prev_r  <= in_measured;
              filt_r  <= '0;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          prev_r  <= meas_r;
          state_r <= ST_MP;
        end
        ST_MP: state_r <= ST_MC;
        ST_MC: state_r <= ST_DS;
        ST_DS: state_r <= ST_DW;
        ST_DW: begin
          if (div_stat.done) state_r <= ST_MD;
        end
        ST_MD: state_r <= ST_RW;
        ST_RW: state_r <= ST_MA;
        ST_MA: state_r <= ST_MB;
        ST_MB: state_r <= ST_MF;
        ST_MF: begin
          filt_r  <= 32'((acc_r + mul_p) >>> 16);
          state_r <= ST_MT;
        end
        ST_MT: state_r <= ST_TQ;
        ST_TQ: state_r <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        meas_r  <= in_measured;
        sp_r    <= in_setpoint;
        angle_r <= in_angle_mode;
        us_r    <= (in_elapsed_us == 32'd0) ? 32'd1000 : in_elapsed_us;
        pterm_r <= '0;
        q_r     <= '0;
      end
      ST_CALC: begin
        err_r <= err_w[EW-1:0];
        chg_r <= chg_w[EW-1:0];
      end
      ST_MC: pterm_r <= TW'(mul_p >>> FRAC_BITS);
      ST_DS: neg_r <= (mul_p < 0);
      ST_DW: begin
        // signed rate, truncated toward zero, saturated to 32 bits
        if (neg_r) begin
          speed_r <= (div_q > 48'h0000_8000_0000) ? S32_MIN : -$signed(div_q[31:0]);
        end else begin
          speed_r <= (div_q > 48'h0000_7FFF_FFFF) ? S32_MAX : $signed(div_q[31:0]);
        end
      end
      ST_RW: raw_r <= sat32(mul_p >>> FRAC_BITS);
      ST_MB: acc_r <= mul_p;
      ST_TQ: begin
        // |filt| / 10 by reciprocal, sign restored
        q_r <= (filt_r < 0) ? -$signed({1'b0, mul_p[63:35]}) : $signed({1'b0, mul_p[63:35]});
      end
      ST_FIN: begin
        if (out_free) begin
          if (total > LIM) begin
            drive_r <= LIM[23:0];
            sat_r   <= 1'b1;
          end else if (total < -LIM) begin
            drive_r <= -LIM24;
            sat_r   <= 1'b1;
          end else begin
            drive_r <= total[23:0];
            sat_r   <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready     = 1'b1;
  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_drive     = drive_r;
  assign out_saturated = sat_r;

  `include "pd_controller_angle_wrap_assert.svh"

  // one item in flight at a time
  `PDC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a clamped result sits exactly on a limit
  `PDC_ASSERT_IMPL(a_sat_on_limit, out_valid && out_saturated, out_drive == LIM24 || out_drive == -LIM24)
  // filter weight always within its clamp range
  `PDC_ASSERT_IMPL(a_alpha_range, 1'b1, alpha_r >= pdc_pkg::ALPHA_MIN && alpha_r <= pdc_pkg::ALPHA_ONE)

endmodule

// ===== rtl/pdc_mul.sv =====
// ----------------------------------------------------------------------------
// pdc_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdc_mul (
  input  logic                                 clk,
  input  logic signed [pdc_pkg::MUL_W-1:0]     op_a,
  input  logic signed [pdc_pkg::MUL_W-1:0]     op_b,
  output logic signed [pdc_pkg::PROD_W-1:0]    prod
);

  logic signed [pdc_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/pdc_div.sv =====
// ----------------------------------------------------------------------------
// pdc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pdc_pkg::DVD_W-1:0]       dividend,
  input  logic [pdc_pkg::DVS_W-1:0]       divisor,
  output logic [pdc_pkg::DVD_W-1:0]       quotient,
  output pdc_pkg::div_stat_t              stat
);

  localparam int CNT_W = $clog2(pdc_pkg::DVD_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(pdc_pkg::DVD_W - 1);

  logic [pdc_pkg::DVD_W-1:0] dvd_r;
  logic [pdc_pkg::DVS_W-1:0] dvs_r;
  logic [pdc_pkg::DVS_W-1:0] rem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [pdc_pkg::DVS_W:0]   rem_sh;
  logic [pdc_pkg::DVS_W:0]   rem_sub;
  logic                      q_bit;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[pdc_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[pdc_pkg::DVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[pdc_pkg::DVS_W-1:0] : rem_sh[pdc_pkg::DVS_W-1:0];
    end
  end

  assign quotient  = dvd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// pd_controller_angle_wrap testbench
// checks every drive result against a local fixed-point loop predictor
// ----------------------------------------------------------------------------
// First, directed samples, a first batch at the default settings: reloads,
// zero elapsed time, angle wrapping at the input limits and saturation in
// both directions. Then the run goes through several register settings
// with random samples under each, including the extremes of every
// register. Both channels idle at random. One long receiver stall fills
// the block, and a sender pause after each phase drains it.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic signed [23:0] drive;
    logic               sat;
  } drive_t;

  // loop predictor plus the queue of expected drive values
  class drive_scoreboard;
    longint kp, kd, alpha, band;
    bit     en_p, en_d;
    longint prev_meas, filt_d;
    drive_t expected_q[$];
    int     errors, checked;

    function new();
      kp = 65536; kd = 0; alpha = 65536; band = 0; en_p = 1; en_d = 1;
      prev_meas = 0; filt_d = 0; errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      longint a;
      case (idx)
        pdc_pkg::REG_GAIN_P:   kp = longint'(signed'(data));
        pdc_pkg::REG_GAIN_D:   kd = longint'(signed'(data));
        pdc_pkg::REG_ALPHA: begin
          a = longint'(data[16:0]);
          if (a < 655) a = 655;
          if (a > 65536) a = 65536;
          alpha = a;
        end
        pdc_pkg::REG_DEADBAND: band = longint'(data[30:0]);
        pdc_pkg::REG_EN_P:     en_p = data[0];
        pdc_pkg::REG_EN_D:     en_d = data[0];
        default: ;
      endcase
    endfunction

    function longint wrap180(longint d);
      longint half, full;
      half = 180 * 65536;
      full = 360 * 65536;
      if (d > half) d -= full;
      if (d > half) d -= full;
      if (d < -half) d += full;
      if (d < -half) d += full;
      return d;
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // one accepted input transfer
    function void note_input(bit func, logic signed [25:0] m, logic signed [25:0] s,
                             bit ang, logic [31:0] us_in);
      longint meas, tgt, us, err, pterm, chg, speed, raw, total, lim;
      drive_t r;
      meas = longint'(m);
      tgt = longint'(s);
      us = longint'({32'b0, us_in});
      r.sat = 0;
      if (func) begin
        prev_meas = meas;
        filt_d = 0;
        r.drive = 0;
        expected_q.push_back(r);
        return;
      end
      if (us == 0) us = 1000;
      err = tgt - meas;
      if (ang) err = wrap180(err);
      if ((err < 0 ? -err : err) < band) err = 0;
      pterm = (err * kp) >>> 16;
      chg = meas - prev_meas;
      if (ang) chg = wrap180(chg);
      speed = clip32((chg * 1000000) / us);
      raw = clip32((speed * kd) >>> 16);
      filt_d = (alpha * raw + (65536 - alpha) * filt_d) >>> 16;
      prev_meas = meas;
      total = 0;
      if (en_p) total += pterm;
      if (en_d) total -= filt_d / 10;
      lim = 100 * 65536;
      if (total > lim) begin total = lim; r.sat = 1; end
      if (total < -lim) begin total = -lim; r.sat = 1; end
      r.drive = total[23:0];
      expected_q.push_back(r);
    endfunction

    // one accepted result transfer
    function void check_result(logic signed [23:0] drive, logic sat);
      drive_t e;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result drive=%0d sat=%0b", drive, sat);
        return;
      end
      e = expected_q.pop_front();
      if (drive !== e.drive || sat !== e.sat) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected drive=%0d sat=%0b, got drive=%0d sat=%0b",
                   checked, e.drive, e.sat, drive, sat);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, in_func, in_angle_mode;
  logic signed [25:0] in_measured, in_setpoint;
  logic [31:0] in_elapsed_us;
  logic out_valid, out_ready, out_saturated;
  logic signed [23:0] out_drive;

  drive_scoreboard sb;
  bit  no_idle;      // quiet window with no random gaps on either side
  bit  rx_hold_req;  // asks the receiver for one long stall
  int  quiet_cycles;
  int  n_items, n_reload, n_cfg;

  localparam int STALL_LEN = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam longint LIM360 = 23592960;

  pd_controller_angle_wrap dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: random ready, one long hold-off on request
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready = 0;
        repeat (STALL_LEN) @(negedge clk);
        rx_hold_req = 0;
      end
      out_ready = no_idle ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end
  end

  // result monitor
  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_drive, out_saturated);

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // offers one item and holds it until the transfer
  task automatic send(bit func, longint m, longint s, bit ang, logic [31:0] us);
    @(negedge clk);
    in_valid = 1;
    in_func = func;
    in_measured = m[25:0];
    in_setpoint = s[25:0];
    in_angle_mode = ang;
    in_elapsed_us = us;
    do @(posedge clk); while (!in_ready);
    sb.note_input(func, m[25:0], s[25:0], ang, us);
    n_items++;
    if (func) n_reload++;
    if (!no_idle && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic longint rand_value();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(0, 47185920)) - LIM360;
      1: return longint'($urandom_range(0, 2 * 65536 * 20)) - 65536 * 20;
      2: return ($urandom_range(0, 1) ? LIM360 : -LIM360) +
                longint'($urandom_range(0, 65536)) * ($urandom_range(0, 1) ? -1 : 1)
                * 0;
      default: return longint'($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200;
    endcase
  endfunction

  function automatic logic [31:0] rand_us();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom_range(1, 2000);
      2: return $urandom_range(2000, 200000);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++)
      send($urandom_range(0, 99) < 5, rand_value(), rand_value(),
           $urandom_range(0, 1), rand_us());
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    cfg_valid = 0; cfg_index = pdc_pkg::REG_GAIN_P; cfg_data = 0;
    in_valid = 0; in_func = 0; in_measured = 0; in_setpoint = 0;
    in_angle_mode = 0; in_elapsed_us = 0;
    no_idle = 0; rx_hold_req = 0;
    n_items = 0; n_reload = 0; n_cfg = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed part at default settings (kp 1.0, kd 0)
    send(0, 0, 0, 0, 0);
    send(0, -LIM360, LIM360, 1, 0);         // 720 degrees wraps twice to zero
    send(0, LIM360, -LIM360, 1, 1);
    send(0, 0, 180 * 65536, 1, 1000);       // exactly +180 stays
    send(0, 0, 181 * 65536, 1, 1000);       // just past wraps negative
    send(0, LIM360, -LIM360, 0, 32'hFFFF_FFFF);  // negative clamp
    send(0, -LIM360, LIM360, 0, 32'hFFFF_FFFF);  // positive clamp
    send(1, 12345678, -LIM360, 0, 0);       // reload
    send(1, -LIM360, LIM360, 1, 32'hFFFF_FFFF);
    send(0, 100 * 65536, 0, 0, 7);          // exactly at the output limit
    drain();
    reg_write(pdc_pkg::REG_GAIN_D, 32'sd65536);
    reg_write(pdc_pkg::REG_DEADBAND, 32'd10 << 16);
    send(0, 0, 10 << 16, 0, 0);             // error equal to deadband is kept
    send(0, 0, (10 << 16) - 1, 0, 500);     // just below becomes zero
    send(0, LIM360, LIM360, 1, 1);          // large change over one microsecond
    send(0, -LIM360, -LIM360, 1, 1);
    send(0, -LIM360, -LIM360, 0, 1);
    send(0, LIM360, 0, 0, 1);               // speed and raw D saturate
    send(0, -LIM360, 0, 0, 1);
    drain();

    // random settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          reg_write(pdc_pkg::REG_GAIN_P, 32'sd98304);
          reg_write(pdc_pkg::REG_GAIN_D, 32'sd30);
          reg_write(pdc_pkg::REG_ALPHA, 32'd0); reg_write(pdc_pkg::REG_DEADBAND, 32'd0);
          reg_write(pdc_pkg::REG_EN_P, 1); reg_write(pdc_pkg::REG_EN_D, 1);
        end
        1: begin
          reg_write(pdc_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
          reg_write(pdc_pkg::REG_GAIN_D, 32'h8000_0000);
          reg_write(pdc_pkg::REG_ALPHA, 32'h0001_FFFF);
          reg_write(pdc_pkg::REG_DEADBAND, 32'hFFFF_FFFF);
        end
        2: begin
          reg_write(pdc_pkg::REG_GAIN_P, 32'h8000_0000);
          reg_write(pdc_pkg::REG_GAIN_D, 32'h7FFF_FFFF);
          reg_write(pdc_pkg::REG_ALPHA, 32'd655); reg_write(pdc_pkg::REG_DEADBAND, 32'd0);
          reg_write(pdc_pkg::REG_EN_P, 0);
        end
        3: begin
          reg_write(pdc_pkg::REG_GAIN_P, $urandom_range(0, 1 << 18) - (1 << 17));
          reg_write(pdc_pkg::REG_GAIN_D, $urandom_range(0, 1 << 12) - (1 << 11));
          reg_write(pdc_pkg::REG_ALPHA, 32'd656); reg_write(pdc_pkg::REG_EN_P, 1);
          reg_write(pdc_pkg::REG_EN_D, 0);
        end
        default: begin
          reg_write(pdc_pkg::REG_GAIN_P, $urandom_range(0, 1 << 19) - (1 << 18));
          reg_write(pdc_pkg::REG_GAIN_D, $urandom_range(0, 1 << 14) - (1 << 13));
          reg_write(pdc_pkg::REG_ALPHA, $urandom_range(0, 32'h1FFFF));
          reg_write(pdc_pkg::REG_DEADBAND, $urandom_range(0, 1 << 21));
          reg_write(pdc_pkg::REG_EN_P, $urandom_range(0, 1));
          reg_write(pdc_pkg::REG_EN_D, $urandom_range(0, 1));
        end
      endcase
      if (ph == 4) no_idle = 1;
      if (ph == 5) no_idle = 0;
      if (ph == 6) begin
        rx_hold_req = 1;   // block fills while the sender keeps offering
        random_items(40);
      end
      random_items(ph == 2 ? 200 : 215);
      drain();             // sender pause until all results are in
    end

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d items (%0d reloads), %0d register writes, %0d results checked",
             n_items, n_reload, n_cfg, sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("mismatch count %0d, results still owed %0d", sb.errors,
               sb.expected_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
